>>> design/emdr_pkg.sv
`default_nettype none
package emdr_pkg;
    typedef enum logic [1:0] {
        OP_READ = 2'd0,
        OP_WRITE = 2'd1,
        OP_RX = 2'd2,
        OP_TX = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        IST_DONE = 2'd0,
        IST_RX_OFF = 2'd1,
        IST_SHORT = 2'd2,
        IST_NOT_OWNED = 2'd3
    } ist_t;

    localparam logic [9:0] IDX_VERSION = 10'h008;
    localparam logic [9:0] IDX_ADDR_HIGH = 10'h010;
    localparam logic [9:0] IDX_ADDR_LOW = 10'h011;
    localparam logic [9:0] IDX_BUS_MODE = 10'h3c0;
    localparam logic [9:0] IDX_TX_POLL = 10'h3c1;
    localparam logic [9:0] IDX_RX_BASE = 10'h3c3;
    localparam logic [9:0] IDX_TX_BASE = 10'h3c4;
    localparam logic [9:0] IDX_STATUS = 10'h3c5;
    localparam logic [9:0] IDX_CONTROL = 10'h3c6;
    localparam logic [9:0] IDX_INT_ENA = 10'h3c7;
    localparam logic [9:0] IDX_CUR_TX = 10'h3d2;
    localparam logic [9:0] IDX_CUR_RX = 10'h3d3;

    localparam logic [0:0] CFG_ADDR_HIGH = 1'b0;
    localparam logic [0:0] CFG_ADDR_LOW = 1'b1;

    localparam logic [31:0] VERSION_VALUE = 32'h0000_1012;
    localparam logic [31:0] ST_TI = 32'h0000_0001;
    localparam logic [31:0] ST_RI = 32'h0000_0040;
    localparam logic [31:0] ST_RU = 32'h0000_0080;
    localparam logic [31:0] ST_AIS = 32'h0000_8000;
    localparam logic [31:0] ST_NIS = 32'h0001_0000;
    localparam logic [31:0] CTL_RX_ENABLE = 32'h0000_0002;
    localparam logic [31:0] DESC_OWN = 32'h8000_0000;
    localparam logic [31:0] DESC_LAST = 32'h2000_0000;
    localparam logic [31:0] DESC_TX_END = 32'h0020_0000;
    localparam logic [15:0] DESC_RX_END = 16'h8000;
    localparam logic [11:0] LEN_MASK = 12'hfff;
    localparam logic [15:0] RX_DESC_FLAGS = 16'h0300;
    localparam logic [13:0] RX_MIN_LEN = 14'd12;
    localparam logic [13:0] RX_CRC_BYTES = 14'd4;

    typedef struct packed {
        logic [1:0] opcode;
        logic [9:0] reg_index;
        logic [31:0] write_value;
        logic [13:0] rx_length;
        logic [31:0] desc_control;
        logic [15:0] desc_buf1_size;
        logic [15:0] desc_buf2_size;
    } item_in_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic irq;
        logic [1:0] item_status;
        logic desc_write;
        logic [31:0] desc_addr;
        logic [31:0] desc_control_out;
        logic [13:0] dma_length;
        logic frame_done;
        logic [13:0] frame_length;
        logic tx_kick;
        logic frame_overflow;
    } item_out_t;
endpackage
`default_nettype wire

>>> design/ethernet_mac_dma_register_block_top.sv
// an accepted item's result item is registered in the output register
// one item per cycle unless stalled; output register and state update share a pass
// a stalled output holds the input side until the result is taken
// reset: asynchronous active low; state registers and station address clear to zero
// after reset a clearing pass zeroes the register memory while s_tready stays low
`default_nettype none
module ethernet_mac_dma_register_block_top #(
    parameter int REG_WORDS = 1024,
    parameter int DESC_BYTES = 16,
    parameter int TX_FRAME_BYTES = 8192
) (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic s_tvalid,
    output logic s_tready,
    // opcode, reg_index, write_value, rx_length, desc_control,
    // desc_buf1_size, desc_buf2_size, zero fill
    input wire logic [127:0] s_tdata,
    output logic m_tvalid,
    input wire logic m_tready,
    // read_data, irq, item_status, desc_write, desc_addr, desc_control_out,
    // dma_length, frame_done, frame_length, tx_kick, frame_overflow, zero fill
    output logic [135:0] m_tdata,
    input wire logic cfg_we,
    input wire logic [0:0] cfg_index,
    input wire logic [31:0] cfg_data
);
    import emdr_pkg::*;

    item_in_t item;
    item_out_t result;
    logic step;
    logic valid_reg;
    logic clearing;

    assign item.opcode = s_tdata[1:0];
    assign item.reg_index = s_tdata[11:2];
    assign item.write_value = s_tdata[43:12];
    assign item.rx_length = s_tdata[57:44];
    assign item.desc_control = s_tdata[89:58];
    assign item.desc_buf1_size = s_tdata[105:90];
    assign item.desc_buf2_size = s_tdata[121:106];

    assign s_tready = !clearing && (!valid_reg || m_tready);
    assign step = s_tvalid && s_tready;
    assign m_tvalid = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    emdr_core #(
        .REG_WORDS(REG_WORDS),
        .DESC_BYTES(DESC_BYTES),
        .TX_FRAME_BYTES(TX_FRAME_BYTES)
    ) u_core (
        .clk(clk),
        .rst_n(rst_n),
        .step(step),
        .item(item),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .clearing(clearing),
        .result(result)
    );

    assign m_tdata = {5'b0, result.frame_overflow, result.tx_kick, result.frame_length,
        result.frame_done, result.dma_length, result.desc_control_out, result.desc_addr,
        result.desc_write, result.item_status, result.irq, result.read_data};
endmodule
`default_nettype wire

>>> design/emdr_core.sv
`default_nettype none
module emdr_core #(
    parameter int REG_WORDS = 1024,
    parameter int DESC_BYTES = 16,
    parameter int TX_FRAME_BYTES = 8192
) (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic step,
    input wire emdr_pkg::item_in_t item,
    input wire logic cfg_we,
    input wire logic [0:0] cfg_index,
    input wire logic [31:0] cfg_data,
    output logic clearing,
    output emdr_pkg::item_out_t result
);
    import emdr_pkg::*;

    localparam int MEM_WORDS = 1024;
    localparam int FRAME_CAP_INT = (TX_FRAME_BYTES < 16383) ? TX_FRAME_BYTES : 16383;
    localparam logic [14:0] FRAME_CAP = 15'(FRAME_CAP_INT);
    localparam logic [31:0] DESC_STEP = 32'(DESC_BYTES);
    localparam logic [12:0] REG_LIMIT = 13'(REG_WORDS);

    // special registers live in flops, the rest of the file is a memory
    logic [31:0] bus_mode_reg, bus_mode_next;
    logic [31:0] rx_base_reg, rx_base_next;
    logic [31:0] tx_base_reg, tx_base_next;
    logic [31:0] status_reg, status_next;
    logic [31:0] control_reg, control_next;
    logic [31:0] int_ena_reg, int_ena_next;
    logic [31:0] cur_tx_reg, cur_tx_next;
    logic [31:0] cur_rx_reg, cur_rx_next;
    logic [31:0] addr_high_reg, addr_high_next;
    logic [31:0] addr_low_reg, addr_low_next;
    logic [13:0] tx_bytes_reg, tx_bytes_next;
    logic tx_over_reg, tx_over_next;

    logic [31:0] mem [MEM_WORDS];
    logic [31:0] mem_rd_reg;
    logic clear_reg;
    logic [9:0] clear_cnt_reg;

    logic [1:0] op_reg;
    logic [9:0] idx_reg;
    logic special_reg;
    logic [31:0] special_data_reg;
    logic in_range_reg;
    item_out_t res_reg, res_next;

    logic in_range;
    logic is_special;
    logic [31:0] special_data;
    logic mem_we;
    logic [12:0] tx_len;
    logic [14:0] tx_sum;
    logic [31:0] dout;

    assign in_range = {3'b0, item.reg_index} < REG_LIMIT;
    assign clearing = clear_reg;

    always_comb
    begin
        is_special = 1'b1;
        special_data = '0;
        unique case (item.reg_index)
            IDX_VERSION: special_data = VERSION_VALUE;
            IDX_ADDR_HIGH: special_data = addr_high_reg;
            IDX_ADDR_LOW: special_data = addr_low_reg;
            IDX_BUS_MODE: special_data = bus_mode_reg;
            IDX_RX_BASE: special_data = rx_base_reg;
            IDX_TX_BASE: special_data = tx_base_reg;
            IDX_STATUS: special_data = status_reg;
            IDX_CONTROL: special_data = control_reg;
            IDX_INT_ENA: special_data = int_ena_reg;
            IDX_CUR_TX: special_data = cur_tx_reg;
            IDX_CUR_RX: special_data = cur_rx_reg;
            default: is_special = 1'b0;
        endcase
    end

    assign mem_we = step && (op_t'(item.opcode) == OP_WRITE) && !is_special && in_range
        && (item.reg_index != IDX_TX_POLL);

    // zero the memory once after reset, one word per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg <= 1'b1;
            clear_cnt_reg <= '0;
        end
        else if (clear_reg)
        begin
            clear_cnt_reg <= clear_cnt_reg + 10'd1;
            if (clear_cnt_reg == 10'h3ff)
            begin
                clear_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clear_reg)
        begin
            mem[clear_cnt_reg] <= '0;
        end
        else if (mem_we)
        begin
            mem[item.reg_index] <= item.write_value;
        end
        if (step)
        begin
            mem_rd_reg <= mem[item.reg_index];
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            op_reg <= item.opcode;
            idx_reg <= item.reg_index;
            special_reg <= is_special;
            special_data_reg <= special_data;
            in_range_reg <= in_range;
        end
    end

    assign tx_len = {1'b0, item.desc_buf1_size[11:0] & LEN_MASK}
        + {1'b0, item.desc_buf2_size[11:0] & LEN_MASK};
    assign tx_sum = {1'b0, tx_bytes_reg} + {2'b0, tx_len};
    assign dout = item.desc_control & ~DESC_OWN;

    always_comb
    begin
        bus_mode_next = bus_mode_reg;
        rx_base_next = rx_base_reg;
        tx_base_next = tx_base_reg;
        status_next = status_reg;
        control_next = control_reg;
        int_ena_next = int_ena_reg;
        cur_tx_next = cur_tx_reg;
        cur_rx_next = cur_rx_reg;
        addr_high_next = addr_high_reg;
        addr_low_next = addr_low_reg;
        tx_bytes_next = tx_bytes_reg;
        tx_over_next = tx_over_reg;
        res_next = '0;
        if (cfg_we)
        begin
            if (cfg_index == CFG_ADDR_HIGH)
            begin
                addr_high_next = cfg_data;
            end
            else
            begin
                addr_low_next = cfg_data;
            end
        end
        if (step)
        begin
            unique case (op_t'(item.opcode))
                OP_READ:
                begin
                end
                OP_WRITE:
                begin
                    unique case (item.reg_index)
                        IDX_BUS_MODE: bus_mode_next = item.write_value & ~32'h1;
                        IDX_TX_POLL: res_next.tx_kick = 1'b1;
                        IDX_STATUS: status_next = status_reg & ~item.write_value;
                        IDX_RX_BASE:
                        begin
                            rx_base_next = item.write_value;
                            cur_rx_next = item.write_value;
                        end
                        IDX_TX_BASE:
                        begin
                            tx_base_next = item.write_value;
                            cur_tx_next = item.write_value;
                        end
                        IDX_CONTROL: control_next = item.write_value;
                        IDX_INT_ENA: int_ena_next = item.write_value;
                        IDX_CUR_TX: cur_tx_next = item.write_value;
                        IDX_CUR_RX: cur_rx_next = item.write_value;
                        IDX_ADDR_HIGH: addr_high_next = item.write_value;
                        IDX_ADDR_LOW: addr_low_next = item.write_value;
                        default:
                        begin
                        end
                    endcase
                end
                OP_RX:
                begin
                    if ((control_reg & CTL_RX_ENABLE) == '0)
                    begin
                        res_next.item_status = IST_RX_OFF;
                    end
                    else if (item.rx_length < RX_MIN_LEN)
                    begin
                        status_next = status_reg | ST_RI | ST_NIS;
                        res_next.item_status = IST_SHORT;
                    end
                    else if ((item.desc_control & DESC_OWN) == '0)
                    begin
                        status_next = status_reg | ST_RU | ST_AIS;
                        res_next.item_status = IST_NOT_OWNED;
                    end
                    else
                    begin
                        res_next.desc_write = 1'b1;
                        res_next.desc_addr = cur_rx_reg;
                        res_next.desc_control_out =
                            {{2'b0, item.rx_length} + {2'b0, RX_CRC_BYTES}, RX_DESC_FLAGS};
                        res_next.dma_length = item.rx_length;
                        cur_rx_next = ((item.desc_buf1_size & DESC_RX_END) != '0)
                            ? rx_base_reg : cur_rx_reg + DESC_STEP;
                        status_next = status_reg | ST_RI | ST_NIS;
                    end
                end
                OP_TX:
                begin
                    if ((item.desc_control & DESC_OWN) == '0)
                    begin
                        res_next.item_status = IST_NOT_OWNED;
                    end
                    else
                    begin
                        tx_bytes_next = tx_sum[13:0];
                        if (tx_sum > FRAME_CAP)
                        begin
                            tx_bytes_next = FRAME_CAP[13:0];
                            tx_over_next = 1'b1;
                        end
                        res_next.dma_length = {1'b0, tx_len};
                        res_next.frame_overflow = tx_over_next;
                        if ((item.desc_control & DESC_LAST) != '0)
                        begin
                            res_next.frame_done = 1'b1;
                            res_next.frame_length = tx_bytes_next;
                            tx_bytes_next = '0;
                            tx_over_next = 1'b0;
                            status_next = status_reg | ST_TI | ST_NIS;
                        end
                        res_next.desc_write = 1'b1;
                        res_next.desc_addr = cur_tx_reg;
                        res_next.desc_control_out = dout;
                        cur_tx_next = ((dout & DESC_TX_END) != '0)
                            ? tx_base_reg : cur_tx_reg + DESC_STEP;
                    end
                end
                default:
                begin
                end
            endcase
        end
        res_next.irq = (status_next & int_ena_next) != '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_mode_reg <= '0;
            rx_base_reg <= '0;
            tx_base_reg <= '0;
            status_reg <= '0;
            control_reg <= '0;
            int_ena_reg <= '0;
            cur_tx_reg <= '0;
            cur_rx_reg <= '0;
            addr_high_reg <= '0;
            addr_low_reg <= '0;
            tx_bytes_reg <= '0;
            tx_over_reg <= 1'b0;
        end
        else
        begin
            bus_mode_reg <= bus_mode_next;
            rx_base_reg <= rx_base_next;
            tx_base_reg <= tx_base_next;
            status_reg <= status_next;
            control_reg <= control_next;
            int_ena_reg <= int_ena_next;
            cur_tx_reg <= cur_tx_next;
            cur_rx_reg <= cur_rx_next;
            addr_high_reg <= addr_high_next;
            addr_low_reg <= addr_low_next;
            tx_bytes_reg <= tx_bytes_next;
            tx_over_reg <= tx_over_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res_next;
        end
    end

    // read data joins the registered result, taken from the read values registered with it
    always_comb
    begin
        result = res_reg;
        if (op_t'(op_reg) == OP_READ)
        begin
            if (special_reg)
            begin
                result.read_data = special_data_reg;
            end
            else if (in_range_reg && idx_reg != IDX_TX_POLL)
            begin
                result.read_data = mem_rd_reg;
            end
            else
            begin
                result.read_data = '0;
            end
        end
    end
endmodule
`default_nettype wire
